FILE: design/source_token_scanner_core_assert.svh
// Assertion macros used by the checker of the token scanner.
`ifndef SOURCE_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SOURCE_TOKEN_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, inactive while reset is applied.
`define STSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("token scanner check failed");

// Next-cycle implication, inactive while reset is applied.
`define STSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("token scanner check failed");

`endif

FILE: design/stsc_pkg.sv
// ----------------------------------------------------------------------------
// stsc_pkg
// Types, token codes and character helpers of the source token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_STRING, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_IDENT,
    M_BANG, M_EQ, M_LT, M_GT, M_AMP, M_PIPE
  } scan_mode_e;

  localparam logic [5:0] K_SLASH   = 6'd22;
  localparam logic [5:0] K_BANG    = 6'd14;
  localparam logic [5:0] K_BANG_EQ = 6'd15;
  localparam logic [5:0] K_EQ      = 6'd16;
  localparam logic [5:0] K_EQ_EQ   = 6'd17;
  localparam logic [5:0] K_LT      = 6'd18;
  localparam logic [5:0] K_LT_EQ   = 6'd19;
  localparam logic [5:0] K_GT      = 6'd20;
  localparam logic [5:0] K_GT_EQ   = 6'd21;
  localparam logic [5:0] K_AND     = 6'd23;
  localparam logic [5:0] K_OR      = 6'd24;
  localparam logic [5:0] K_DOT     = 6'd7;
  localparam logic [5:0] K_STRING  = 6'd25;
  localparam logic [5:0] K_NUMBER  = 6'd26;
  localparam logic [5:0] K_IDENT   = 6'd27;
  localparam logic [5:0] K_KW_FN   = 6'd28;
  localparam logic [5:0] K_END     = 6'd38;
  localparam logic [5:0] K_ERROR   = 6'd39;

  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_UNEXPECTED = 3'd1;
  localparam logic [2:0] E_LONE_AMP   = 3'd2;
  localparam logic [2:0] E_LONE_PIPE  = 3'd3;
  localparam logic [2:0] E_UNTERM_STR = 3'd4;

  localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;
  localparam int unsigned RUN_MAX = 4;

  // Keyword text, right-aligned ASCII; the last keyword comes first.
  localparam logic [9:0][47:0] KW_TEXT = {
    48'h0066_616c_7365,  // false
    48'h0000_7472_7565,  // true
    48'h006d_6f64_656c,  // model
    48'h0070_7269_6e74,  // print
    48'h7265_7475_726e,  // return
    48'h0077_6869_6c65,  // while
    48'h0000_656c_7365,  // else
    48'h0000_0000_6966,  // if
    48'h0000_006c_6574,  // let
    48'h0000_0000_666e   // fn
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] digit_value;
    logic [7:0]  fraction_digits;
    logic        value_overflow;
    logic [2:0]  error_code;
  } tok_info_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  // Single-byte punctuation; bit 6 flags a match.
  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      8'h28:   r = {1'b1, 6'd0};
      8'h29:   r = {1'b1, 6'd1};
      8'h7b:   r = {1'b1, 6'd2};
      8'h7d:   r = {1'b1, 6'd3};
      8'h5b:   r = {1'b1, 6'd4};
      8'h5d:   r = {1'b1, 6'd5};
      8'h2c:   r = {1'b1, 6'd6};
      8'h2e:   r = {1'b1, 6'd7};
      8'h3b:   r = {1'b1, 6'd8};
      8'h2d:   r = {1'b1, 6'd9};
      8'h2b:   r = {1'b1, 6'd10};
      8'h2a:   r = {1'b1, 6'd11};
      8'h25:   r = {1'b1, 6'd12};
      8'h40:   r = {1'b1, 6'd13};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // Identifier kind from its first six bytes; short flags length <= 6.
  function automatic logic [5:0] ident_kind(input logic [47:0] kwp, input logic short);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < 10; i++) begin
      if (short && (kwp == KW_TEXT[i])) k = K_KW_FN + 6'(i);
    end
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: design/stsc_front.sv
// ----------------------------------------------------------------------------
// stsc_front
// Front end: classifies one accepted byte a cycle and builds its token run.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_front import stsc_pkg::*; #(
  parameter int POS_BITS  = 20,
  parameter int LINE_BITS = 20,
  localparam int TOK_W    = $bits(tok_info_t) + 2 * POS_BITS + LINE_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [7:0]                ch_i,
  input  wire logic                      has_char_i,
  input  wire logic                      end_of_source_i,
  output logic                           run_valid_o,
  output logic [2:0]                     run_cnt_o,
  output logic [RUN_MAX-1:0][TOK_W-1:0]  run_toks_o
);

  typedef struct packed {
    tok_info_t              info;
    logic [POS_BITS-1:0]    start;
    logic [POS_BITS-1:0]    len;
    logic [LINE_BITS-1:0]   line;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } flush_t;

  scan_mode_e            mode_q, mode_d;
  logic [POS_BITS-1:0]   pos_q, pos_d, ts_q, ts_d;
  logic [LINE_BITS-1:0]  line_q, line_d;
  logic [30:0]           acc_q, acc_d;
  logic [7:0]            fc_q, fc_d;
  logic                  ovf_q, ovf_d;
  logic [47:0]           kwp_q, kwp_d;
  tok_t [RUN_MAX-1:0]    toks;
  logic [2:0]            n;

  function automatic tok_t mk(input logic [5:0] kind, input logic [POS_BITS-1:0] st,
                              input logic [POS_BITS-1:0] ln, input logic [LINE_BITS-1:0] lc,
                              input logic num, input logic [30:0] acc,
                              input logic [7:0] fc, input logic ovf, input logic [2:0] err);
    tok_t t;
    t.info.kind            = kind;
    t.info.digit_value     = num ? acc : 31'd0;
    t.info.fraction_digits = num ? fc : 8'd0;
    t.info.value_overflow  = num ? ovf : 1'b0;
    t.info.error_code      = err;
    t.start                = st;
    t.len                  = ln;
    t.line                 = lc;
    return t;
  endfunction

  // Pending token of mode m ending at p; a number's trailing dot adds a K_DOT.
  function automatic flush_t do_flush(input scan_mode_e m, input logic [POS_BITS-1:0] ts,
                                      input logic [LINE_BITS-1:0] lc, input logic [30:0] acc,
                                      input logic [7:0] fc, input logic ovf,
                                      input logic [47:0] kwp, input logic [POS_BITS-1:0] p);
    flush_t f;
    logic [POS_BITS-1:0] sp, dotp, one;
    sp   = p - ts;
    dotp = p - POS_BITS'(1);
    one  = POS_BITS'(1);
    f    = '0;
    unique case (m)
      M_STRING: begin
        f.n = 2'd1; f.t0 = mk(K_ERROR, ts, sp, lc, 1'b0, acc, fc, ovf, E_UNTERM_STR);
      end
      M_NUM_INT, M_NUM_FRAC: begin
        f.n = 2'd1; f.t0 = mk(K_NUMBER, ts, sp, lc, 1'b1, acc, fc, ovf, E_NONE);
      end
      M_NUM_DOT: begin
        f.n  = 2'd2;
        f.t0 = mk(K_NUMBER, ts, dotp - ts, lc, 1'b1, acc, fc, ovf, E_NONE);
        f.t1 = mk(K_DOT, dotp, one, lc, 1'b0, acc, fc, ovf, E_NONE);
      end
      M_IDENT: begin
        f.n  = 2'd1;
        f.t0 = mk(ident_kind(kwp, sp <= POS_BITS'(6)), ts, sp, lc, 1'b0, acc, fc, ovf,
                  E_NONE);
      end
      M_BANG: begin f.n = 2'd1; f.t0 = mk(K_BANG, ts, one, lc, 1'b0, acc, fc, ovf, E_NONE); end
      M_EQ:   begin f.n = 2'd1; f.t0 = mk(K_EQ, ts, one, lc, 1'b0, acc, fc, ovf, E_NONE); end
      M_LT:   begin f.n = 2'd1; f.t0 = mk(K_LT, ts, one, lc, 1'b0, acc, fc, ovf, E_NONE); end
      M_GT:   begin f.n = 2'd1; f.t0 = mk(K_GT, ts, one, lc, 1'b0, acc, fc, ovf, E_NONE); end
      M_AMP: begin
        f.n = 2'd1; f.t0 = mk(K_ERROR, ts, one, lc, 1'b0, acc, fc, ovf, E_LONE_AMP);
      end
      M_PIPE: begin
        f.n = 2'd1; f.t0 = mk(K_ERROR, ts, one, lc, 1'b0, acc, fc, ovf, E_LONE_PIPE);
      end
      default: f.n = 2'd0;
    endcase
    return f;
  endfunction

  always_comb begin
    logic [7:0]          c;
    logic [POS_BITS-1:0] p, one;
    logic                flush_now, start_now;
    logic [34:0]         v;
    logic [6:0]          sk;
    flush_t              f;
    c         = ch_i;
    p         = pos_q;
    one       = POS_BITS'(1);
    flush_now = 1'b0;
    start_now = 1'b0;
    v         = '0;
    sk        = '0;
    f         = '0;
    mode_d    = mode_q;
    pos_d     = pos_q;
    ts_d      = ts_q;
    line_d    = line_q;
    acc_d     = acc_q;
    fc_d      = fc_q;
    ovf_d     = ovf_q;
    kwp_d     = kwp_q;
    toks      = '0;
    n         = 3'd0;

    if (accept_i && has_char_i) begin
      unique case (mode_d)
        M_COMMENT: if (c == 8'h0a) begin mode_d = M_IDLE; start_now = 1'b1; end
        M_STRING: begin
          if (c == 8'h22) begin
            toks[n[1:0]] = mk(K_STRING, ts_d, p + one - ts_d, line_d, 1'b0, acc_d, fc_d,
                              ovf_d, E_NONE);
            n      = n + 3'd1;
            mode_d = M_IDLE;
          end else if (c == 8'h0a) begin
            if (line_d != '1) line_d = line_d + LINE_BITS'(1);
          end
        end
        M_NUM_INT: begin
          if (is_digit(c)) begin
            v = 35'(acc_d) * 35'd10 + 35'(c - 8'h30);
            if (v > 35'(ACC_MAX)) begin acc_d = ACC_MAX; ovf_d = 1'b1; end
            else acc_d = v[30:0];
          end else if (c == 8'h2e) begin
            mode_d = M_NUM_DOT;
          end else begin
            flush_now = 1'b1; start_now = 1'b1;
          end
        end
        M_NUM_DOT, M_NUM_FRAC: begin
          if (is_digit(c)) begin
            v = 35'(acc_d) * 35'd10 + 35'(c - 8'h30);
            if (v > 35'(ACC_MAX)) begin acc_d = ACC_MAX; ovf_d = 1'b1; end
            else acc_d = v[30:0];
            if (fc_d == 8'hff) ovf_d = 1'b1;
            else fc_d = fc_d + 8'd1;
            mode_d = M_NUM_FRAC;
          end else begin
            flush_now = 1'b1; start_now = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if ((p - ts_d) < POS_BITS'(6)) kwp_d = {kwp_d[39:0], c};
          end else begin
            flush_now = 1'b1; start_now = 1'b1;
          end
        end
        M_BANG, M_EQ, M_LT, M_GT, M_AMP, M_PIPE: begin
          if ((c == 8'h3d) && (mode_d == M_BANG || mode_d == M_EQ || mode_d == M_LT ||
                               mode_d == M_GT)) begin
            toks[n[1:0]] = mk((mode_d == M_BANG) ? K_BANG_EQ :
                              (mode_d == M_EQ)   ? K_EQ_EQ   :
                              (mode_d == M_LT)   ? K_LT_EQ   : K_GT_EQ,
                              ts_d, POS_BITS'(2), line_d, 1'b0, acc_d, fc_d, ovf_d, E_NONE);
            n      = n + 3'd1;
            mode_d = M_IDLE;
          end else if ((c == 8'h26) && (mode_d == M_AMP)) begin
            toks[n[1:0]] = mk(K_AND, ts_d, POS_BITS'(2), line_d, 1'b0, acc_d, fc_d, ovf_d,
                              E_NONE);
            n      = n + 3'd1;
            mode_d = M_IDLE;
          end else if ((c == 8'h7c) && (mode_d == M_PIPE)) begin
            toks[n[1:0]] = mk(K_OR, ts_d, POS_BITS'(2), line_d, 1'b0, acc_d, fc_d, ovf_d,
                              E_NONE);
            n      = n + 3'd1;
            mode_d = M_IDLE;
          end else begin
            flush_now = 1'b1; start_now = 1'b1;
          end
        end
        default: begin mode_d = M_IDLE; start_now = 1'b1; end
      endcase

      if (flush_now) begin
        f = do_flush(mode_d, ts_d, line_d, acc_d, fc_d, ovf_d, kwp_d, p);
        if (f.n != 2'd0) begin toks[n[1:0]] = f.t0; n = n + 3'd1; end
        if (f.n == 2'd2) begin toks[n[1:0]] = f.t1; n = n + 3'd1; end
        mode_d = M_IDLE;
      end

      if (start_now) begin
        sk = single_kind(c);
        if (sk[6]) begin
          toks[n[1:0]] = mk(sk[5:0], p, one, line_d, 1'b0, acc_d, fc_d, ovf_d, E_NONE);
          n = n + 3'd1;
        end else begin
          ts_d = p;
          priority if (c == 8'h2f) begin
            toks[n[1:0]] = mk(K_SLASH, p, one, line_d, 1'b0, acc_d, fc_d, ovf_d, E_NONE);
            n = n + 3'd1;
          end else if (c == 8'h21) mode_d = M_BANG;
          else if (c == 8'h3d) mode_d = M_EQ;
          else if (c == 8'h3c) mode_d = M_LT;
          else if (c == 8'h3e) mode_d = M_GT;
          else if (c == 8'h26) mode_d = M_AMP;
          else if (c == 8'h7c) mode_d = M_PIPE;
          else if (c == 8'h23) mode_d = M_COMMENT;
          else if (c == 8'h20 || c == 8'h0d || c == 8'h09) mode_d = mode_d;
          else if (c == 8'h0a) begin
            if (line_d != '1) line_d = line_d + LINE_BITS'(1);
          end else if (c == 8'h22) mode_d = M_STRING;
          else if (is_digit(c)) begin
            acc_d  = 31'(c - 8'h30);
            fc_d   = 8'd0;
            ovf_d  = 1'b0;
            mode_d = M_NUM_INT;
          end else if (is_alpha(c)) begin
            kwp_d  = 48'(c);
            mode_d = M_IDENT;
          end else begin
            toks[n[1:0]] = mk(K_ERROR, p, one, line_d, 1'b0, acc_d, fc_d, ovf_d,
                              E_UNEXPECTED);
            n = n + 3'd1;
          end
        end
      end
      pos_d = p + one;
    end

    if (accept_i && end_of_source_i) begin
      f = do_flush(mode_d, ts_d, line_d, acc_d, fc_d, ovf_d, kwp_d, pos_d);
      if (f.n != 2'd0) begin toks[n[1:0]] = f.t0; n = n + 3'd1; end
      if (f.n == 2'd2) begin toks[n[1:0]] = f.t1; n = n + 3'd1; end
      toks[n[1:0]] = mk(K_END, pos_d, '0, line_d, 1'b0, acc_d, fc_d, ovf_d, E_NONE);
      n      = n + 3'd1;
      mode_d = M_IDLE;
      pos_d  = '0;
      ts_d   = '0;
      line_d = LINE_BITS'(1);
      acc_d  = '0;
      fc_d   = '0;
      ovf_d  = 1'b0;
      kwp_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pos_q  <= '0;
      ts_q   <= '0;
      line_q <= LINE_BITS'(1);
      acc_q  <= '0;
      fc_q   <= '0;
      ovf_q  <= 1'b0;
      kwp_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
      line_q <= line_d;
      acc_q  <= acc_d;
      fc_q   <= fc_d;
      ovf_q  <= ovf_d;
      kwp_q  <= kwp_d;
    end
  end

  assign run_valid_o = accept_i && (n != 3'd0);
  assign run_cnt_o   = n;
  always_comb begin
    for (int i = 0; i < RUN_MAX; i++) run_toks_o[i] = toks[i];
  end

endmodule

`default_nettype wire

FILE: design/stsc_runq.sv
// ----------------------------------------------------------------------------
// stsc_runq
// Two-entry queue of token runs between the scanner and the token output.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_runq #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = entry_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) entry_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i && !full_o) wp_q <= !wp_q;
      if (rd_i && valid_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'((wr_i && !full_o) ? 1 : 0) - 2'((rd_i && valid_o) ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

FILE: design/stsc_back.sv
// ----------------------------------------------------------------------------
// stsc_back
// Token output: walks the head run a token a cycle into a free output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_back import stsc_pkg::*; #(
  parameter int POS_BITS  = 20,
  parameter int LINE_BITS = 20,
  localparam int TOK_W    = $bits(tok_info_t) + 2 * POS_BITS + LINE_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           run_valid_i,
  input  wire logic [2:0]                     run_cnt_i,
  input  wire logic [RUN_MAX-1:0][TOK_W-1:0]  run_toks_i,
  output logic                                run_pop_o,
  input  wire logic                           pop,
  output logic                                empty,
  output logic [TOK_W-1:0]                    tok_o,
  output logic                                last_o
);

  logic [1:0]       idx_q, idx_d;
  logic             ovalid_q, ovalid_d;
  logic [TOK_W-1:0] tok_q;
  logic             last_q, last_now, load;

  assign load      = run_valid_i && (!ovalid_q || pop);
  assign last_now  = ({1'b0, idx_q} == (run_cnt_i - 3'd1));
  assign run_pop_o = load && last_now;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
      idx_d    = last_now ? 2'd0 : idx_q + 2'd1;
    end else if (pop) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= run_toks_i[idx_q];
      last_q <= last_now;
    end
  end

  assign empty  = !ovalid_q;
  assign tok_o  = tok_q;
  assign last_o = last_q;

endmodule

`default_nettype wire

FILE: design/source_token_scanner_core.sv
// ----------------------------------------------------------------------------
// source_token_scanner_core
// Streaming tokenizer: source bytes in, classified tokens out.
// ----------------------------------------------------------------------------
//   Channel   Handshake        Word
//   input     push / full      ch_i, has_char_i, end_of_source_i
//   output    pop / empty      token_kind_o ... last_of_run_o
//
// The scanner takes one source word per cycle while the run queue is not full
// and delivers one token per cycle while the receiver pops. A word that closes
// several tokens (up to four) is held as one run in a two-entry queue, and the
// output stage walks it one token a cycle. The input side stalls (full) only
// when both queue entries hold runs. Reset returns the scanner to the idle mode
// at position zero on line one and empties the run queue and the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module source_token_scanner_core import stsc_pkg::*; #(
  parameter int POS_BITS  = 20,
  parameter int LINE_BITS = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [7:0]           ch_i,
  input  wire logic                 has_char_i,
  input  wire logic                 end_of_source_i,
  input  wire logic                 pop,
  output logic                      empty,
  output logic [5:0]                token_kind_o,
  output logic [POS_BITS-1:0]       start_pos_o,
  output logic [POS_BITS-1:0]       text_length_o,
  output logic [LINE_BITS-1:0]      line_number_o,
  output logic [30:0]               digit_value_o,
  output logic [7:0]                fraction_digits_o,
  output logic                      value_overflow_o,
  output logic [2:0]                error_code_o,
  output logic                      last_of_run_o
);

  localparam int TOK_W = $bits(tok_info_t) + 2 * POS_BITS + LINE_BITS;
  localparam int RUN_W = RUN_MAX * TOK_W + 3;

  typedef struct packed {
    tok_info_t              info;
    logic [POS_BITS-1:0]    start;
    logic [POS_BITS-1:0]    len;
    logic [LINE_BITS-1:0]   line;
  } tok_t;

  // The front end only moves when the run queue can take what it produces.
  logic                           accept;
  logic                           fr_valid, q_valid, q_pop;
  logic [2:0]                     fr_cnt, q_cnt;
  logic [RUN_MAX-1:0][TOK_W-1:0]  fr_toks, q_toks;
  logic [TOK_W-1:0]               out_bits;
  tok_t                           out_tok;

  assign accept = push && !full;

  stsc_front #(.POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .ch_i            (ch_i),
    .has_char_i      (has_char_i),
    .end_of_source_i (end_of_source_i),
    .run_valid_o     (fr_valid),
    .run_cnt_o       (fr_cnt),
    .run_toks_o      (fr_toks)
  );

  stsc_runq #(.WIDTH(RUN_W)) u_runq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fr_valid),
    .wdata_i ({fr_cnt, fr_toks}),
    .full_o  (full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rdata_o ({q_cnt, q_toks})
  );

  stsc_back #(.POS_BITS(POS_BITS), .LINE_BITS(LINE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (q_valid),
    .run_cnt_i   (q_cnt),
    .run_toks_i  (q_toks),
    .run_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .tok_o       (out_bits),
    .last_o      (last_of_run_o)
  );

  assign out_tok           = out_bits;
  assign token_kind_o      = out_tok.info.kind;
  assign digit_value_o     = out_tok.info.digit_value;
  assign fraction_digits_o = out_tok.info.fraction_digits;
  assign value_overflow_o  = out_tok.info.value_overflow;
  assign error_code_o      = out_tok.info.error_code;
  assign start_pos_o       = out_tok.start;
  assign text_length_o     = out_tok.len;
  assign line_number_o     = out_tok.line;

endmodule

`default_nettype wire

FILE: design/stsc_checker.sv
// ----------------------------------------------------------------------------
// stsc_checker
// Port-level checks on the token output of the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

`include "source_token_scanner_core_assert.svh"

module stsc_checker import stsc_pkg::*; #(
  parameter int POS_BITS  = 20,
  parameter int LINE_BITS = 20
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 push,
  input wire logic                 full,
  input wire logic [7:0]           ch_i,
  input wire logic                 has_char_i,
  input wire logic                 end_of_source_i,
  input wire logic                 pop,
  input wire logic                 empty,
  input wire logic [5:0]           token_kind_o,
  input wire logic [POS_BITS-1:0]  start_pos_o,
  input wire logic [POS_BITS-1:0]  text_length_o,
  input wire logic [LINE_BITS-1:0] line_number_o,
  input wire logic [30:0]          digit_value_o,
  input wire logic [7:0]           fraction_digits_o,
  input wire logic                 value_overflow_o,
  input wire logic [2:0]           error_code_o,
  input wire logic                 last_of_run_o
);

  // Only error tokens carry an error code.
  `STSC_ASSERT_IMP(a_err_code, clk_i, rst_ni, !empty, ((token_kind_o == K_ERROR) == (error_code_o != E_NONE)))

  // Number fields stay zero outside number tokens.
  `STSC_ASSERT_IMP(a_num_zero, clk_i, rst_ni, !empty && (token_kind_o != K_NUMBER), (digit_value_o == 31'd0) && (fraction_digits_o == 8'd0) && !value_overflow_o)

  // End of source always closes its run with an empty token.
  `STSC_ASSERT_IMP(a_end_last, clk_i, rst_ni, !empty && (token_kind_o == K_END), last_of_run_o && (text_length_o == '0))

  // A waiting token holds until it is taken.
  `STSC_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(token_kind_o) && $stable(start_pos_o))

endmodule

bind source_token_scanner_core stsc_checker #(
  .POS_BITS  (POS_BITS),
  .LINE_BITS (LINE_BITS)
) u_stsc_checker (.*);

`default_nettype wire

FILE: dv/tb_source_token_scanner_core.sv
// ----------------------------------------------------------------------------
// tb_source_token_scanner_core
// Self-checking bench for the streaming token scanner.
// ----------------------------------------------------------------------------
// Source words are pushed through the push/full queue and every accepted word
// is also run through a behavioral scanner kept in this bench. That scanner
// adds the tokens the word should produce to a queue of pending tokens. Each
// token popped from the block is compared field by field with the oldest
// pending one. A short table of directed words comes first. Random source
// text built from language fragments follows, with noise mixed in. Both sides
// idle in random bursts, and the receiver once holds off long enough for the
// block to fill up and stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_source_token_scanner_core;
  import stsc_pkg::*;

  // One token as it leaves the block.
  typedef struct {
    logic [5:0]  kind;
    logic [19:0] start;
    logic [19:0] len;
    logic [19:0] line;
    logic [30:0] dval;
    logic [7:0]  frac;
    logic        ovf;
    logic [2:0]  err;
    logic        last;
  } token_t;

  // One row of the directed table. When chk is set, the first token that the
  // word produces must have the kind and error code typed into the row.
  typedef struct {
    logic [7:0] ch;
    logic       has;
    logic       eos;
    logic       chk;
    logic [5:0] kind;
    logic [2:0] err;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  ch_i = '0;
  logic        has_char_i = 1'b0;
  logic        end_of_source_i = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [5:0]  token_kind_o;
  logic [19:0] start_pos_o;
  logic [19:0] text_length_o;
  logic [19:0] line_number_o;
  logic [30:0] digit_value_o;
  logic [7:0]  fraction_digits_o;
  logic        value_overflow_o;
  logic [2:0]  error_code_o;
  logic        last_of_run_o;

  int unsigned fail_count = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  token_t      pending_tokens[$];
  token_t      word_tokens[$];

  // Behavioral scanner state.
  scan_mode_e  mode_r;
  logic [19:0] pos_r;
  logic [19:0] tstart_r;
  logic [19:0] line_r;
  logic [30:0] acc_r;
  logic [7:0]  frac_r;
  logic        ovf_r;
  logic [47:0] kwp_r;

  string punct_s = "(){}[],.;-+*%@";
  string kw_s[10] = '{"fn", "let", "if", "else", "while", "return", "print", "model",
                      "true", "false"};

  always #5 clk_i = ~clk_i;

  source_token_scanner_core u_top (
    .clk_i, .rst_ni, .push, .full, .ch_i, .has_char_i, .end_of_source_i, .pop, .empty,
    .token_kind_o, .start_pos_o, .text_length_o, .line_number_o, .digit_value_o,
    .fraction_digits_o, .value_overflow_o, .error_code_o, .last_of_run_o
  );

  function automatic bit digit_b(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_b(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic void scanner_reset();
    mode_r = M_IDLE;
    pos_r = '0;
    tstart_r = '0;
    line_r = 20'd1;
    acc_r = '0;
    frac_r = '0;
    ovf_r = 1'b0;
    kwp_r = '0;
  endfunction

  function automatic void emit_token(logic [5:0] kind, logic [19:0] start, logic [19:0] len,
                                     bit num, logic [2:0] err);
    token_t t;
    t.kind = kind;
    t.start = start;
    t.len = len;
    t.line = line_r;
    t.dval = num ? acc_r : '0;
    t.frac = num ? frac_r : '0;
    t.ovf = num ? ovf_r : 1'b0;
    t.err = err;
    t.last = 1'b0;
    word_tokens.push_back(t);
  endfunction

  function automatic void add_digit(logic [7:0] c, bit in_frac);
    logic [34:0] v;
    v = 35'(acc_r) * 35'd10 + 35'(c - "0");
    if (v > 35'(ACC_MAX)) begin
      v = 35'(ACC_MAX);
      ovf_r = 1'b1;
    end
    acc_r = v[30:0];
    if (in_frac) begin
      if (frac_r == 8'hFF) ovf_r = 1'b1;
      else frac_r++;
    end
  endfunction

  function automatic void next_line();
    if (line_r != '1) line_r++;
  endfunction

  // Identifiers of up to six bytes whose text equals a keyword become that
  // keyword; the length is the distance the position counter has moved.
  function automatic logic [5:0] ident_or_keyword(logic [19:0] len);
    logic [47:0] packed_kw;
    for (int k = 0; k < 10; k++) begin
      packed_kw = '0;
      for (int i = 0; i < kw_s[k].len(); i++) packed_kw = {packed_kw[39:0], kw_s[k][i]};
      if (len <= 20'd6 && len == 20'(kw_s[k].len()) && packed_kw == kwp_r)
        return K_KW_FN + 6'(k);
    end
    return K_IDENT;
  endfunction

  // Closes whatever token is still open at position p.
  function automatic void close_open_token(logic [19:0] p);
    logic [19:0] dotp;
    case (mode_r)
      M_STRING: emit_token(K_ERROR, tstart_r, p - tstart_r, 0, E_UNTERM_STR);
      M_NUM_INT, M_NUM_FRAC: emit_token(K_NUMBER, tstart_r, p - tstart_r, 1, E_NONE);
      M_NUM_DOT: begin
        // A trailing dot with no digit after it is its own token.
        dotp = p - 20'd1;
        emit_token(K_NUMBER, tstart_r, dotp - tstart_r, 1, E_NONE);
        emit_token(K_DOT, dotp, 20'd1, 0, E_NONE);
      end
      M_IDENT: emit_token(ident_or_keyword(p - tstart_r), tstart_r, p - tstart_r, 0, E_NONE);
      M_BANG: emit_token(K_BANG, tstart_r, 20'd1, 0, E_NONE);
      M_EQ: emit_token(K_EQ, tstart_r, 20'd1, 0, E_NONE);
      M_LT: emit_token(K_LT, tstart_r, 20'd1, 0, E_NONE);
      M_GT: emit_token(K_GT, tstart_r, 20'd1, 0, E_NONE);
      M_AMP: emit_token(K_ERROR, tstart_r, 20'd1, 0, E_LONE_AMP);
      M_PIPE: emit_token(K_ERROR, tstart_r, 20'd1, 0, E_LONE_PIPE);
      default: ;
    endcase
    mode_r = M_IDLE;
  endfunction

  function automatic void begin_token(logic [7:0] c, logic [19:0] p);
    for (int i = 0; i < punct_s.len(); i++) begin
      if (punct_s[i] == c) begin
        emit_token(6'(i), p, 20'd1, 0, E_NONE);
        return;
      end
    end
    tstart_r = p;
    case (c)
      "/": emit_token(K_SLASH, p, 20'd1, 0, E_NONE);
      "!": mode_r = M_BANG;
      "=": mode_r = M_EQ;
      "<": mode_r = M_LT;
      ">": mode_r = M_GT;
      "&": mode_r = M_AMP;
      "|": mode_r = M_PIPE;
      "#": mode_r = M_COMMENT;
      " ", "\r", "\t": ;
      "\n": next_line();
      "\"": mode_r = M_STRING;
      default: begin
        if (digit_b(c)) begin
          acc_r = '0;
          frac_r = '0;
          ovf_r = 1'b0;
          add_digit(c, 0);
          mode_r = M_NUM_INT;
        end else if (alpha_b(c)) begin
          kwp_r = 48'(c);
          mode_r = M_IDENT;
        end else begin
          emit_token(K_ERROR, p, 20'd1, 0, E_UNEXPECTED);
        end
      end
    endcase
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic [19:0] p);
    case (mode_r)
      M_COMMENT: begin
        if (c == "\n") begin
          mode_r = M_IDLE;
          begin_token(c, p);
        end
        return;
      end
      M_STRING: begin
        if (c == "\"") begin
          emit_token(K_STRING, tstart_r, p + 20'd1 - tstart_r, 0, E_NONE);
          mode_r = M_IDLE;
        end else if (c == "\n") begin
          next_line();
        end
        return;
      end
      M_NUM_INT: begin
        if (digit_b(c)) begin
          add_digit(c, 0);
          return;
        end
        if (c == ".") begin
          mode_r = M_NUM_DOT;
          return;
        end
      end
      M_NUM_DOT, M_NUM_FRAC: begin
        if (digit_b(c)) begin
          add_digit(c, 1);
          mode_r = M_NUM_FRAC;
          return;
        end
      end
      M_IDENT: begin
        if (alpha_b(c) || digit_b(c)) begin
          if (p - tstart_r < 20'd6) kwp_r = {kwp_r[39:0], c};
          return;
        end
      end
      M_BANG, M_EQ, M_LT, M_GT: begin
        if (c == "=") begin
          case (mode_r)
            M_BANG:  emit_token(K_BANG_EQ, tstart_r, 20'd2, 0, E_NONE);
            M_EQ:    emit_token(K_EQ_EQ, tstart_r, 20'd2, 0, E_NONE);
            M_LT:    emit_token(K_LT_EQ, tstart_r, 20'd2, 0, E_NONE);
            default: emit_token(K_GT_EQ, tstart_r, 20'd2, 0, E_NONE);
          endcase
          mode_r = M_IDLE;
          return;
        end
      end
      M_AMP: begin
        if (c == "&") begin
          emit_token(K_AND, tstart_r, 20'd2, 0, E_NONE);
          mode_r = M_IDLE;
          return;
        end
      end
      M_PIPE: begin
        if (c == "|") begin
          emit_token(K_OR, tstart_r, 20'd2, 0, E_NONE);
          mode_r = M_IDLE;
          return;
        end
      end
      default: begin
        begin_token(c, p);
        return;
      end
    endcase
    close_open_token(p);
    begin_token(c, p);
  endfunction

  // Works out the tokens of one accepted word and queues them as pending.
  function automatic void scan_word(logic [7:0] c, logic has, logic eos);
    word_tokens.delete();
    if (has) begin
      scan_byte(c, pos_r);
      pos_r++;
    end
    if (eos) begin
      close_open_token(pos_r);
      emit_token(K_END, pos_r, 20'd0, 0, E_NONE);
      scanner_reset();
    end
    if (word_tokens.size() > 0) word_tokens[$].last = 1'b1;
    foreach (word_tokens[i]) pending_tokens.push_back(word_tokens[i]);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Drives one word at the falling edge and holds it until accepted. The
  // sender idles in random bursts unless the run is in its quiet tail. Push
  // stays high on return; the caller lowers it before it waits.
  task automatic send_word(logic [7:0] c, logic has, logic eos);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    push <= 1'b1;
    ch_i <= c;
    has_char_i <= has;
    end_of_source_i <= eos;
    do @(posedge clk_i); while (full);
    scan_word(c, has, eos);
    @(negedge clk_i);
  endtask

  // The receiver decides pop once per falling edge. A hold request keeps pop
  // low for a long counted stretch so that the block backs up.
  initial begin : receiver
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 14);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Each popped token is compared with the oldest pending one.
  always @(posedge clk_i) begin
    token_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("token with nothing pending, kind", token_kind_o, -1);
      end else begin
        e = pending_tokens.pop_front();
        if (token_kind_o !== e.kind) report_mismatch("token_kind", token_kind_o, e.kind);
        if (start_pos_o !== e.start) report_mismatch("start_pos", start_pos_o, e.start);
        if (text_length_o !== e.len) report_mismatch("text_length", text_length_o, e.len);
        if (line_number_o !== e.line) report_mismatch("line_number", line_number_o, e.line);
        if (digit_value_o !== e.dval) report_mismatch("digit_value", digit_value_o, e.dval);
        if (fraction_digits_o !== e.frac)
          report_mismatch("fraction_digits", fraction_digits_o, e.frac);
        if (value_overflow_o !== e.ovf)
          report_mismatch("value_overflow", value_overflow_o, e.ovf);
        if (error_code_o !== e.err) report_mismatch("error_code", error_code_o, e.err);
        if (last_of_run_o !== e.last) report_mismatch("last_of_run", last_of_run_o, e.last);
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("source_token_scanner_core verification failed");
    $finish;
  end

  // Appends a random piece of source text to the byte queue.
  function automatic void add_fragment(ref logic [7:0] text[$]);
    int n;
    string s;
    case ($urandom_range(0, 12))
      0: begin
        s = kw_s[$urandom_range(0, 9)];
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      end
      1: begin
        // Identifier starting with an underscore or an a, then letters and digits.
        n = $urandom_range(1, 9);
        text.push_back("_" + 8'($urandom_range(0, 1)) * ("a" - "_"));
        for (int i = 1; i < n; i++) begin
          case ($urandom_range(0, 2))
            0: text.push_back(8'("a" + $urandom_range(0, 25)));
            1: text.push_back(8'("A" + $urandom_range(0, 25)));
            default: text.push_back(8'("0" + $urandom_range(0, 9)));
          endcase
        end
      end
      2, 3: begin
        // Integer, fraction or a number followed by a dangling dot; long
        // digit strings saturate the value.
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) text.push_back(8'("0" + $urandom_range(0, 9)));
        case ($urandom_range(0, 2))
          0: begin
            text.push_back(".");
            repeat ($urandom_range(1, 4)) text.push_back(8'("0" + $urandom_range(0, 9)));
          end
          1: text.push_back(".");
          default: ;
        endcase
      end
      4: begin
        text.push_back("\"");
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 5) == 0) text.push_back("\n");
          else text.push_back(8'($urandom_range(32, 126)));
        end
        if ($urandom_range(0, 4) != 0) text.push_back("\"");
      end
      5: begin
        text.push_back("#");
        repeat ($urandom_range(0, 5)) text.push_back(8'($urandom_range(32, 126)));
        text.push_back("\n");
      end
      6, 7: begin
        s = "!=<>&|";
        text.push_back(s[$urandom_range(0, 5)]);
        s = "=&| a";
        if ($urandom_range(0, 1)) text.push_back(s[$urandom_range(0, 4)]);
      end
      8, 9: begin
        s = "(){}[],.;-+*%@/";
        text.push_back(s[$urandom_range(0, 14)]);
      end
      10, 11: begin
        s = " \n\t\r";
        text.push_back(s[$urandom_range(0, 3)]);
      end
      default: text.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  initial begin : stimulus
    row_t        rows[$];
    logic [7:0]  text[$];
    int          sent;
    bit          held;

    rows = '{
      '{".",    1, 0, 1, K_DOT,    E_NONE},
      '{"@",    1, 0, 0, K_DOT,    E_NONE},
      '{8'hFF,  1, 0, 1, K_ERROR,  E_UNEXPECTED},
      '{8'h00,  1, 0, 1, K_ERROR,  E_UNEXPECTED},
      '{"&",    1, 0, 0, K_DOT,    E_NONE},
      '{" ",    1, 0, 1, K_ERROR,  E_LONE_AMP},
      '{"|",    1, 0, 0, K_DOT,    E_NONE},
      '{"|",    1, 0, 1, K_OR,     E_NONE},
      '{"|",    1, 0, 0, K_DOT,    E_NONE},
      '{"x",    1, 0, 1, K_ERROR,  E_LONE_PIPE},
      '{"!",    1, 0, 1, K_IDENT,  E_NONE},
      '{"=",    1, 0, 1, K_BANG_EQ, E_NONE},
      '{"<",    1, 0, 0, K_DOT,    E_NONE},
      '{"=",    1, 0, 1, K_LT_EQ,  E_NONE},
      '{"9",    1, 0, 0, K_DOT,    E_NONE},
      '{".",    1, 0, 0, K_DOT,    E_NONE},
      '{"a",    1, 0, 1, K_NUMBER, E_NONE},
      '{"#",    1, 0, 1, K_IDENT,  E_NONE},
      '{"z",    1, 0, 0, K_DOT,    E_NONE},
      '{"\n",   1, 0, 0, K_DOT,    E_NONE},
      '{8'h00,  0, 0, 0, K_DOT,    E_NONE},
      '{"\"",   1, 0, 0, K_DOT,    E_NONE},
      '{"q",    1, 0, 0, K_DOT,    E_NONE},
      '{8'h00,  0, 1, 1, K_ERROR,  E_UNTERM_STR},
      '{8'h00,  0, 1, 1, K_END,    E_NONE},
      '{"/",    1, 1, 1, K_SLASH,  E_NONE}
    };

    scanner_reset();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[r]) begin
      send_word(rows[r].ch, rows[r].has, rows[r].eos);
      if (rows[r].chk) begin
        if (word_tokens.size() == 0)
          report_mismatch("table row without token, row", r, -1);
        else if (word_tokens[0].kind !== rows[r].kind || word_tokens[0].err !== rows[r].err)
          report_mismatch("table row kind", word_tokens[0].kind, rows[r].kind);
      end
    end

    // Let the block drain completely before the random text starts.
    push <= 1'b0;
    wait (pending_tokens.size() == 0);
    @(negedge clk_i);

    // A fraction with more than 255 digits saturates the digit count.
    text.push_back("7");
    text.push_back(".");
    repeat (260) text.push_back(8'("0" + $urandom_range(0, 9)));
    text.push_back(";");

    sent = 0;
    held = 1'b0;
    while (sent < 380) begin
      if (text.size() == 0) begin
        repeat ($urandom_range(1, 4)) add_fragment(text);
        // Now and then the source ends, or a word carries no byte at all.
        case ($urandom_range(0, 24))
          0: begin
            text.delete();
            send_word(8'($urandom), 1'b0, 1'b1);
            sent++;
          end
          1: send_word(8'($urandom), 1'b0, 1'b0);
          default: ;
        endcase
        continue;
      end
      if (!held && sent > 280) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (sent > 330) no_idle = 1'b1;
      send_word(text.pop_front(), 1'b1, text.size() == 0 && $urandom_range(0, 15) == 0);
      sent++;
    end
    send_word(8'h00, 1'b0, 1'b1);
    push <= 1'b0;

    wait (pending_tokens.size() == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("source_token_scanner_core verification clean");
    end else begin
      $display("source_token_scanner_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/stsc_pkg.sv
design/stsc_front.sv
design/stsc_runq.sv
design/stsc_back.sv
design/source_token_scanner_core.sv
design/stsc_checker.sv
dv/tb_source_token_scanner_core.sv
